// ===== design/mnk_pkg.sv =====
// Shared types and register indexes for the masked nearest-K pixel select block.
// Used by mnk_dist, mnk_cell and masked_nearest_k_pixel_select_top.
package mnk_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned INDEX_W = 24;
   localparam int unsigned FILL_W  = 7;

   // Register indexes of the csr channel
   typedef enum logic [3:0] {
      REG_DEPTH_MODE  = 4'd0,
      REG_USE_REGION  = 4'd1,
      REG_KEEP_COUNT  = 4'd2,
      REG_IMAGE_WIDTH = 4'd3,
      REG_REGION_X0   = 4'd4,
      REG_REGION_Y0   = 4'd5,
      REG_REGION_W    = 4'd6,
      REG_REGION_H    = 4'd7
   } csr_index_type;

   // One kept pixel held by a cell
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [INDEX_W-1:0] index;
   } entry_type;

   // Pixel sideband that travels with the distance pipeline
   typedef struct packed {
      logic               active;
      logic               order;
      logic               last;
      logic [FILL_W-1:0]  lim;
      logic [INDEX_W-1:0] index;
   } item_type;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic               insert;
      logic               order;
      logic               shift_out;
      logic [FILL_W-1:0]  fill;
      logic [FILL_W-1:0]  lim;
      logic [KEY_W-1:0]   key;
      logic [INDEX_W-1:0] index;
   } cell_ctrl_type;

endpackage

// ===== design/mnk_dist.sv =====
// Three-stage squared-distance pipeline: magnitudes, squares, saturated sum.
// Carries the pixel sideband alongside; depends on mnk_pkg.
module mnk_dist #(
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  mnk_pkg::item_type            in_item,
   input  logic signed [COORD_BITS-1:0] pos_x,
   input  logic signed [COORD_BITS-1:0] pos_y,
   input  logic signed [COORD_BITS-1:0] pos_z,
   output logic                         out_valid,
   output mnk_pkg::item_type            out_item,
   output logic [mnk_pkg::KEY_W-1:0]    out_key
);

   localparam int unsigned SQ_W  = 2 * COORD_BITS;
   localparam int unsigned SUM_W = SQ_W + 2;

   logic [2:0]                v_ff;
   mnk_pkg::item_type         item1_ff, item2_ff, item3_ff;
   logic [COORD_BITS-1:0]     mx_ff, my_ff, mz_ff;
   logic [COORD_BITS-1:0]     mx_in, my_in, mz_in;
   logic [SQ_W-1:0]           sx_ff, sy_ff, sz_ff;
   logic [SUM_W-1:0]          sum;
   logic [63:0]               sum_ext;
   logic [mnk_pkg::KEY_W-1:0] key_ff, key_in;

   assign mx_in = pos_x[COORD_BITS-1] ? $unsigned(-pos_x) : $unsigned(pos_x);
   assign my_in = pos_y[COORD_BITS-1] ? $unsigned(-pos_y) : $unsigned(pos_y);
   assign mz_in = pos_z[COORD_BITS-1] ? $unsigned(-pos_z) : $unsigned(pos_z);

   assign sum     = SUM_W'(sx_ff) + SUM_W'(sy_ff) + SUM_W'(sz_ff);
   assign sum_ext = 64'(sum);
   assign key_in  = (sum_ext > 64'hFFFF_FFFF) ? '1 : sum_ext[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      item1_ff <= in_item;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      mz_ff    <= mz_in;
      item2_ff <= item1_ff;
      sx_ff    <= SQ_W'(mx_ff * mx_ff);
      sy_ff    <= SQ_W'(my_ff * my_ff);
      sz_ff    <= SQ_W'(mz_ff * mz_ff);
      item3_ff <= item2_ff;
      key_ff   <= key_in;
   end

   assign out_valid = v_ff[2];
   assign out_item  = item3_ff;
   assign out_key   = key_ff;

endmodule

// ===== design/mnk_cell.sv =====
// One slot of the kept list: compares, inserts, shifts right on insert, left on readout.
// Depends on mnk_pkg.
module mnk_cell #(
   parameter int unsigned POS = 0
) (
   input  logic                  clock,
   input  mnk_pkg::cell_ctrl_type ctrl,
   input  logic                  found_in,
   input  mnk_pkg::entry_type    left,
   input  mnk_pkg::entry_type    right,
   output logic                  found_out,
   output mnk_pkg::entry_type    entry
);

   mnk_pkg::entry_type entry_ff, entry_in;
   logic               occupied, at_end, in_lim, hit;

   assign occupied  = mnk_pkg::FILL_W'(POS) < ctrl.fill;
   assign at_end    = mnk_pkg::FILL_W'(POS) == ctrl.fill;
   assign in_lim    = mnk_pkg::FILL_W'(POS) < ctrl.lim;
   assign hit       = occupied && !ctrl.order && (entry_ff.key > ctrl.key);
   assign found_out = found_in || hit || at_end;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert && in_lim && found_in) begin
         entry_in = left;
      end else if (ctrl.insert && in_lim && (hit || at_end)) begin
         entry_in.key   = ctrl.key;
         entry_in.index = ctrl.index;
      end else if (ctrl.shift_out) begin
         entry_in = right;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== design/masked_nearest_k_pixel_select_top.sv =====
// Top level of the masked nearest-K pixel select: config registers, raster counters,
// candidate test, distance pipeline, cell chain and result readout. Uses mnk_pkg,
// mnk_dist and mnk_cell.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, mask_set .. last_pixel | in
//   rsp     | rsp_valid/ready, pixel_index .. last    | out
//   csr     | csr_valid/ready, csr_index, csr_data    | in, always ready
//
// One pixel per cycle while a frame streams; each pixel reaches the cell chain after the
// registered magnitude, square and sum stages.
// After the last pixel, req_ready stays low until the final result of the frame sits
// in the output register; rsp stalls hold it low for longer.
// Results leave from cell 0 while the chain shifts toward it, one per rsp transfer.
// Synchronous reset clears counters, fill, state and valid flags; no clearing pass.
module masked_nearest_k_pixel_select_top #(
   parameter int unsigned MAX_KEEP   = 64,
   parameter int unsigned MAX_DIM    = 4096,
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mask_set,
   input  logic                         req_point_valid,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic                         req_last_pixel,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [23:0]                  rsp_pixel_index,
   output logic [31:0]                  rsp_dist_sq,
   output logic                         rsp_none_found,
   output logic                         rsp_last_result,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [3:0]                   csr_index,
   input  logic [15:0]                  csr_data
);

   localparam int unsigned CW = $clog2(MAX_DIM);
   localparam int unsigned FW = mnk_pkg::FILL_W;

   typedef enum logic {RUN, EMIT} state_type;

   // configuration
   logic        depth_mode_ff, use_region_ff;
   logic [6:0]  keep_count_ff;
   logic [12:0] image_width_ff, region_w_ff, region_h_ff;
   logic [11:0] region_x0_ff, region_y0_ff;

   // raster counters
   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [23:0]   pix_ff;
   logic [12:0]   width_eff;
   logic          req_xfer, busy_ff, busy_in;
   logic          region_on, outside, cand;
   logic [FW-1:0] lim;
   mnk_pkg::item_type item_in;

   // pipeline output
   logic                      s3_valid;
   mnk_pkg::item_type         s3_item;
   logic [mnk_pkg::KEY_W-1:0] s3_key;

   // chain and readout
   logic [FW-1:0] fill_ff, fill_in, n_cur, fill_ins, fill_after, emit_count;
   logic [FW-1:0] emit_cnt_ff;
   state_type     state_ff;
   logic          load, final_load;
   mnk_pkg::cell_ctrl_type ctrl;
   mnk_pkg::entry_type     cell_entry [MAX_KEEP];
   mnk_pkg::entry_type     new_entry;
   logic [MAX_KEEP:0]      found;

   logic        rsp_valid_ff, rsp_none_ff, rsp_last_ff;
   logic [23:0] rsp_index_ff;
   logic [31:0] rsp_dist_ff;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_mode_ff  <= 1'b1;
         use_region_ff  <= 1'b0;
         keep_count_ff  <= 7'd64;
         image_width_ff <= 13'd640;
         region_x0_ff   <= '0;
         region_y0_ff   <= '0;
         region_w_ff    <= '0;
         region_h_ff    <= '0;
      end else if (csr_valid) begin
         unique case (mnk_pkg::csr_index_type'(csr_index))
            mnk_pkg::REG_DEPTH_MODE:  depth_mode_ff  <= csr_data[0];
            mnk_pkg::REG_USE_REGION:  use_region_ff  <= csr_data[0];
            mnk_pkg::REG_KEEP_COUNT:  keep_count_ff  <= csr_data[6:0];
            mnk_pkg::REG_IMAGE_WIDTH: image_width_ff <= csr_data[12:0];
            mnk_pkg::REG_REGION_X0:   region_x0_ff   <= csr_data[11:0];
            mnk_pkg::REG_REGION_Y0:   region_y0_ff   <= csr_data[11:0];
            mnk_pkg::REG_REGION_W:    region_w_ff    <= csr_data[12:0];
            mnk_pkg::REG_REGION_H:    region_h_ff    <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // ---------------- accept side ----------------
   assign req_ready = !busy_ff;
   assign req_xfer  = req_valid && req_ready;

   assign lim = (keep_count_ff > 7'(MAX_KEEP)) ? 7'(MAX_KEEP) : keep_count_ff;

   assign width_eff = (image_width_ff == '0) ? 13'd1 :
                      (image_width_ff > 13'(MAX_DIM)) ? 13'(MAX_DIM) : image_width_ff;

   assign region_on = use_region_ff && (region_w_ff != '0) && (region_h_ff != '0);
   assign outside   = (14'(col_ff) < 14'(region_x0_ff)) ||
                      (14'(col_ff) >= 14'(region_x0_ff) + 14'(region_w_ff)) ||
                      (14'(row_ff) < 14'(region_y0_ff)) ||
                      (14'(row_ff) >= 14'(region_y0_ff) + 14'(region_h_ff));
   assign cand      = req_mask_set && !(region_on && outside);

   always_comb begin
      item_in.active = cand && (lim != '0) && (!depth_mode_ff || req_point_valid);
      item_in.order  = !depth_mode_ff;
      item_in.last   = req_last_pixel;
      item_in.lim    = lim;
      item_in.index  = pix_ff;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (14'(col_ff) + 14'd1 >= 14'(width_eff)) begin
         col_in = '0;
         row_in = ((CW+1)'(row_ff) + 1'b1 >= (CW+1)'(MAX_DIM)) ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         pix_ff <= '0;
      end else if (req_xfer) begin
         if (req_last_pixel) begin
            col_ff <= '0;
            row_ff <= '0;
            pix_ff <= '0;
         end else begin
            col_ff <= col_in;
            row_ff <= row_in;
            pix_ff <= pix_ff + 24'd1;
         end
      end
   end

   assign busy_in = (req_xfer && req_last_pixel) ? 1'b1 : (final_load ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   mnk_dist #(
      .COORD_BITS(COORD_BITS)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_xfer),
      .in_item  (item_in),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .pos_z    (req_pos_z),
      .out_valid(s3_valid),
      .out_item (s3_item),
      .out_key  (s3_key)
   );

   // ---------------- cell chain ----------------
   assign n_cur      = (fill_ff < s3_item.lim) ? fill_ff : s3_item.lim;
   assign fill_ins   = (n_cur < s3_item.lim) ? n_cur + 1'b1 : n_cur;
   assign fill_after = (s3_valid && s3_item.active) ? fill_ins : fill_ff;
   assign emit_count = (fill_after < s3_item.lim) ? fill_after : s3_item.lim;

   assign load       = (state_ff == EMIT) && (!rsp_valid_ff || rsp_ready);
   assign final_load = load && (emit_cnt_ff <= FW'(1));

   always_comb begin
      ctrl.insert    = s3_valid && s3_item.active;
      ctrl.order     = s3_item.order;
      ctrl.shift_out = load && (emit_cnt_ff != '0);
      ctrl.fill      = n_cur;
      ctrl.lim       = s3_item.lim;
      ctrl.key       = s3_item.order ? mnk_pkg::KEY_W'(n_cur) : s3_key;
      ctrl.index     = s3_item.index;
      new_entry.key   = ctrl.key;
      new_entry.index = ctrl.index;
   end

   assign found[0] = 1'b0;

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      mnk_cell #(
         .POS(i)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .found_in (found[i]),
         .left     ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
         .right    (cell_entry[(i == MAX_KEEP - 1) ? i : i + 1]),
         .found_out(found[i+1]),
         .entry    (cell_entry[i])
      );
   end

   assign fill_in = final_load ? '0 : fill_after;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // ---------------- readout ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RUN;
         rsp_valid_ff <= 1'b0;
         emit_cnt_ff  <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            if (emit_cnt_ff == '0) begin
               rsp_index_ff <= '0;
               rsp_dist_ff  <= '0;
               rsp_none_ff  <= 1'b1;
            end else begin
               rsp_index_ff <= cell_entry[0].index;
               rsp_dist_ff  <= cell_entry[0].key;
               rsp_none_ff  <= 1'b0;
               emit_cnt_ff  <= emit_cnt_ff - 1'b1;
            end
            rsp_last_ff <= final_load;
            if (final_load) begin
               state_ff <= RUN;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s3_valid && s3_item.last) begin
            state_ff    <= EMIT;
            emit_cnt_ff <= emit_count;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_dist_sq     = rsp_dist_ff;
   assign rsp_none_found  = rsp_none_ff;
   assign rsp_last_result = rsp_last_ff;

   // ---------------- checks ----------------
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> busy_ff)
      else $error("readout running while input is open");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_KEEP))
      else $error("fill beyond chain length");

   a_no_insert_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT) |-> !s3_valid)
      else $error("pixel reached chain during readout");

   a_final_done: assert property (@(posedge clock) disable iff (reset)
      final_load |=> (state_ff == RUN) && !busy_ff && (fill_ff == '0))
      else $error("frame not closed after final result");

endmodule
